>>> src/rfes_pkg.sv
// ----------------------------------------------------------------------------
// RTC fields to epoch seconds: shared types and constants
// Queue entry layout, calendar constants and the BCD and month helpers.
// ----------------------------------------------------------------------------
package rfes_pkg;

  localparam int unsigned EPOCH_YEAR     = 1970;
  localparam int unsigned LAST_YEAR      = 2099;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned HOURS_HALF_DAY = 12;
  localparam int unsigned YEARS_PER_CENT = 100;
  localparam int unsigned MONTH_FIRST    = 1;
  localparam int unsigned MONTH_LAST     = 12;
  localparam int unsigned MONTH_FEB      = 2;

  // One classified snapshot, as held between the front and the back.
  typedef struct packed {
    logic       ok;        // year and month in range
    logic [7:0] year_off;  // year minus the epoch year
    logic [3:0] month;     // 1 to 12 when ok
    logic [7:0] day;
    logic [7:0] hour;      // already in 24-hour form
    logic [7:0] minute;
    logic [7:0] second;
  } rfes_item_t;

  // Packed BCD byte to binary; nibbles above nine are not rejected.
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    logic [7:0] tens;
    tens = 8'(b[7:4]) * 8'd10;
    return tens + 8'(b[3:0]);
  endfunction

  // Days before the first of a month in a common year.
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> src/rtc_fields_to_epoch_seconds_unit.sv
// ----------------------------------------------------------------------------
// RTC fields to epoch seconds unit
// Registers on the path: the queue store, the back end's first stage, its output.
// Throughput: one transfer per cycle unless the output stalls; both back stages
// use constant multipliers only, and the queue decouples input from output.
// Reset: rst (synchronous, active high) empties the queue and pipeline; no
// results are pending afterwards.
// ----------------------------------------------------------------------------
module rtc_fields_to_epoch_seconds_unit
  import rfes_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // second_raw, minute_raw, hour_raw, day_raw, month_raw, year_raw, century_raw
  input  logic [55:0] s_axis_tdata,
  // binary_mode, mode_24_hour
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // epoch_seconds
  output logic [31:0] m_axis_tdata,
  // valid_res
  output logic [0:0]  m_axis_tuser
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rfes_item_t       front_item;
  rfes_item_t       back_item;
  logic             back_valid, back_ready;
  logic [CNT_W-1:0] queue_level;

  // The front decodes the snapshot combinationally; a transfer on the input
  // side writes the classified item straight into the queue.
  rfes_front u_front (
    .binary_mode  (s_axis_tuser[0]),
    .mode_24_hour (s_axis_tuser[1]),
    .second_raw   (s_axis_tdata[7:0]),
    .minute_raw   (s_axis_tdata[15:8]),
    .hour_raw     (s_axis_tdata[23:16]),
    .day_raw      (s_axis_tdata[31:24]),
    .month_raw    (s_axis_tdata[39:32]),
    .year_raw     (s_axis_tdata[47:40]),
    .century_raw  (s_axis_tdata[55:48]),
    .item         (front_item)
  );

  // The queue's ready depends on its own fill level only, so the input side
  // never waits on the output handshake combinationally.
  rfes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_axis_tvalid),
    .push_ready (s_axis_tready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item),
    .level      (queue_level)
  );

  // The back end turns the item into seconds; its last stage is the output
  // register, and an out-of-range date gives zero with the flag cleared.
  rfes_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (back_valid),
    .item_ready  (back_ready),
    .item        (back_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_seconds (m_axis_tdata),
    .out_ok      (m_axis_tuser[0])
  );

  // The queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    queue_level <= CNT_W'(QUEUE_DEPTH))
    else $error("queue level exceeds its depth");

  // The fill level moves by at most one entry per cycle.
  a_level_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (queue_level == $past(queue_level))
                 || (queue_level == $past(queue_level) + 1'b1)
                 || (queue_level == $past(queue_level) - 1'b1))
    else $error("queue level jumped");

  // A result marked invalid carries zero seconds.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("invalid result with non-zero seconds");

endmodule

>>> src/rfes_front.sv
// ----------------------------------------------------------------------------
// RTC fields to epoch seconds: front decoder
// Decodes BCD, folds 12-hour time into 24-hour form and checks the date range.
// ----------------------------------------------------------------------------
module rfes_front
  import rfes_pkg::*;
(
  input  logic       binary_mode,
  input  logic       mode_24_hour,
  input  logic [7:0] second_raw,
  input  logic [7:0] minute_raw,
  input  logic [7:0] hour_raw,
  input  logic [7:0] day_raw,
  input  logic [7:0] month_raw,
  input  logic [7:0] year_raw,
  input  logic [7:0] century_raw,
  output rfes_item_t item
);

  logic [7:0]  sec_dec, min_dec, hour_dec, day_dec, mon_dec, yr_dec, cen_dec;
  logic [7:0]  hour_low_bcd;
  logic [7:0]  hour_pm;
  logic [7:0]  hour_24;
  logic [15:0] year;
  logic        year_ok, month_ok;

  assign hour_low_bcd = from_bcd({1'b0, hour_raw[6:0]});

  always_comb begin
    if (binary_mode) begin
      sec_dec  = second_raw;
      min_dec  = minute_raw;
      hour_dec = hour_raw;
      day_dec  = day_raw;
      mon_dec  = month_raw;
      yr_dec   = year_raw;
      cen_dec  = century_raw;
    end else begin
      sec_dec  = from_bcd(second_raw);
      min_dec  = from_bcd(minute_raw);
      // The PM flag in bit 7 survives BCD decoding untouched.
      hour_dec = {hour_raw[7], hour_low_bcd[6:0]};
      day_dec  = from_bcd(day_raw);
      mon_dec  = from_bcd(month_raw);
      yr_dec   = from_bcd(year_raw);
      cen_dec  = from_bcd(century_raw);
    end
  end

  // Twelve-hour clock: 12 AM is midnight, 12 PM stays noon.
  assign hour_pm = 8'(hour_dec[6:0]) + 8'(HOURS_HALF_DAY);

  always_comb begin
    hour_24 = hour_dec;
    if (!mode_24_hour) begin
      if (hour_dec[7]) begin
        hour_24 = (hour_pm == 8'(2 * HOURS_HALF_DAY)) ? 8'(HOURS_HALF_DAY) : hour_pm;
      end else if (hour_dec == 8'(HOURS_HALF_DAY)) begin
        hour_24 = '0;
      end
    end
  end

  assign year     = 16'(cen_dec) * 16'(YEARS_PER_CENT) + 16'(yr_dec);
  assign year_ok  = (year >= 16'(EPOCH_YEAR)) && (year <= 16'(LAST_YEAR));
  assign month_ok = (mon_dec >= 8'(MONTH_FIRST)) && (mon_dec <= 8'(MONTH_LAST));

  always_comb begin
    item          = '0;
    item.ok       = year_ok && month_ok;
    item.year_off = 8'(year - 16'(EPOCH_YEAR));
    item.month    = mon_dec[3:0];
    item.day      = day_dec;
    item.hour     = hour_24;
    item.minute   = min_dec;
    item.second   = sec_dec;
  end

endmodule

>>> src/rfes_queue.sv
// ----------------------------------------------------------------------------
// RTC fields to epoch seconds: item queue
// Small first-in first-out buffer that lets the front and back stall apart.
// ----------------------------------------------------------------------------
module rfes_queue
  import rfes_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push_valid,
  output logic                           push_ready,
  input  rfes_item_t                     push_item,
  output logic                           pop_valid,
  input  logic                           pop_ready,
  output rfes_item_t                     pop_item,
  output logic [$clog2(DEPTH+1)-1:0]     level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfes_item_t       store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             do_push, do_pop;

  assign push_ready = (level != CNT_W'(DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_item   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/rfes_back.sv
// ----------------------------------------------------------------------------
// RTC fields to epoch seconds: back end
// Two-stage pipeline: day count and time of day, then the scaled sum.
// ----------------------------------------------------------------------------
module rfes_back
  import rfes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  rfes_item_t  item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_seconds,
  output logic        out_ok
);

  logic        s1_valid, s1_ok;
  logic [15:0] s1_days;   // day count plus one, so that day zero stays positive
  logic [19:0] s1_tod;
  logic        s1_free, out_free;

  logic [16:0] yr_days;
  logic [5:0]  leap_days;
  logic        leap_extra;
  logic [15:0] days_next;
  logic [19:0] tod_next;
  logic [32:0] day_secs;
  logic [31:0] total;

  assign out_free   = !out_valid || out_ready;
  assign s1_free    = !s1_valid || out_free;
  assign item_ready = s1_free;

  // Leap years before this one; inside 1970..2099 every fourth year is leap,
  // 2000 included, so the year is leap when the offset is two modulo four.
  assign yr_days    = 17'(item.year_off) * 17'(DAYS_PER_YEAR);
  assign leap_days  = 6'((9'(item.year_off) + 9'd1) >> 2);
  assign leap_extra = (item.year_off[1:0] == 2'b10) && (item.month > 4'(MONTH_FEB));
  assign days_next  = 16'(yr_days + 17'(leap_days) + 17'(days_before_month(item.month))
                        + 17'(leap_extra) + 17'(item.day));
  assign tod_next   = 20'(20'(item.hour) * 20'(SECS_PER_HOUR)
                        + 20'(item.minute) * 20'(SECS_PER_MIN) + 20'(item.second));

  // Sum wraps modulo 2^32, as does the day-zero borrow.
  assign day_secs = 33'(s1_days) * 33'(SECS_PER_DAY);
  assign total    = 32'(day_secs + 33'(s1_tod) - 33'(SECS_PER_DAY));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= item_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item_valid) begin
      s1_ok   <= item.ok;
      s1_days <= days_next;
      s1_tod  <= tod_next;
    end
    if (out_free && s1_valid) begin
      out_ok      <= s1_ok;
      out_seconds <= s1_ok ? total : '0;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the RTC fields to epoch seconds unit
// Drives register snapshots in binary and BCD form, in 12-hour and 24-hour
// mode, and checks every epoch result against an independent calculation,
// under random idling on both stream sides and at full rate.
// ----------------------------------------------------------------------------
module testbench
  import rfes_pkg::*;
();

  // One snapshot of raw clock register bytes.
  typedef struct {
    logic       binary;
    logic       hour24;
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
  } snapshot_t;

  // One expected result: the seconds count and the in-range flag.
  typedef struct {
    logic [31:0] seconds;
    logic        in_range;
  } epoch_t;

  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned SETTLE_CYCLES    = 10;

  // Holds the expected epoch values of accepted snapshots, oldest first.
  class epoch_scoreboard;
    epoch_t      awaited_epochs[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned bcd_value(logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function int unsigned month_start(int unsigned month);
      int unsigned table_days[12];
      table_days = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      return table_days[month - 1];
    endfunction

    function epoch_t predict_epoch(snapshot_t s);
      int unsigned sec, minute, hour, day, month, yr, cen, year;
      longint unsigned days;
      bit leap;
      epoch_t e;
      sec    = s.second;
      minute = s.minute;
      hour   = s.hour;
      day    = s.day;
      month  = s.month;
      yr     = s.year;
      cen    = s.century;
      if (!s.binary) begin
        sec    = bcd_value(s.second);
        minute = bcd_value(s.minute);
        hour   = bcd_value({1'b0, s.hour[6:0]}) | (s.hour & 8'h80);
        day    = bcd_value(s.day);
        month  = bcd_value(s.month);
        yr     = bcd_value(s.year);
        cen    = bcd_value(s.century);
      end
      if (!s.hour24) begin
        if (hour[7]) begin
          hour = (hour & 32'h7F) + HOURS_HALF_DAY;
          if (hour == 2 * HOURS_HALF_DAY) hour = HOURS_HALF_DAY;
        end else if (hour == HOURS_HALF_DAY) begin
          hour = 0;
        end
      end
      year = cen * YEARS_PER_CENT + yr;
      e.seconds  = '0;
      e.in_range = 1'b0;
      if (year >= EPOCH_YEAR && year <= LAST_YEAR &&
          month >= MONTH_FIRST && month <= MONTH_LAST) begin
        leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        // A day of zero steps back one day; the unsigned wrap is harmless
        // because only the low 32 bits of the total are kept.
        days = longint'(year - EPOCH_YEAR) * DAYS_PER_YEAR
             + (year - (EPOCH_YEAR - 1)) / 4
             + month_start(month)
             + ((month > MONTH_FEB && leap) ? 1 : 0)
             + day - 1;
        e.seconds  = 32'(days * SECS_PER_DAY + longint'(hour) * SECS_PER_HOUR
                         + minute * SECS_PER_MIN + sec);
        e.in_range = 1'b1;
      end
      return e;
    endfunction

    function void note_snapshot(snapshot_t s);
      awaited_epochs.push_back(predict_epoch(s));
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [31:0] seconds, logic in_range);
      epoch_t want;
      if (awaited_epochs.size() == 0) begin
        report_mismatch("unexpected result seconds", seconds, 0);
      end else begin
        want = awaited_epochs.pop_front();
        if (seconds !== want.seconds)
          report_mismatch("epoch_seconds", seconds, want.seconds);
        if (in_range !== want.in_range)
          report_mismatch("valid_res", in_range, want.in_range);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // second, minute, hour, day, month, year, century raw bytes
  logic [55:0] s_axis_tdata = '0;
  // binary_mode, mode_24_hour
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // epoch_seconds
  logic [31:0] m_axis_tdata;
  // valid_res
  logic [0:0]  m_axis_tuser;

  int unsigned     send_idle_pct = 29;
  int unsigned     recv_idle_pct = 81;
  epoch_scoreboard sb;

  rtc_fields_to_epoch_seconds_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic snapshot_t make_snapshot(logic binary, logic hour24,
                                              logic [7:0] century, logic [7:0] year,
                                              logic [7:0] month, logic [7:0] day,
                                              logic [7:0] hour, logic [7:0] minute,
                                              logic [7:0] second);
    snapshot_t s;
    s.binary  = binary;
    s.hour24  = hour24;
    s.century = century;
    s.year    = year;
    s.month   = month;
    s.day     = day;
    s.hour    = hour;
    s.minute  = minute;
    s.second  = second;
    return s;
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned v);
    return 8'((((v / 10) % 16) << 4) | (v % 10));
  endfunction

  // Mostly plausible calendar dates with random content, some dates just
  // outside the supported years, and a share of wholly random bytes.
  function automatic snapshot_t random_snapshot();
    snapshot_t   s;
    int unsigned pick, year, month, day, hour, minute, second;
    logic        pm;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      s = make_snapshot(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));
    end else begin
      year   = (pick < 25) ? $urandom_range(1960, 2110) : $urandom_range(1970, 2099);
      month  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      day    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 31);
      minute = $urandom_range(0, 59);
      second = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
      s.binary = 1'($urandom);
      s.hour24 = 1'($urandom);
      pm       = 1'($urandom);
      hour     = s.hour24 ? $urandom_range(0, 23) : $urandom_range(1, 12);
      if (s.binary) begin
        s.century = 8'(year / 100);
        s.year    = 8'(year % 100);
        s.month   = 8'(month);
        s.day     = 8'(day);
        s.hour    = 8'(hour);
        s.minute  = 8'(minute);
        s.second  = 8'(second);
      end else begin
        s.century = to_bcd(year / 100);
        s.year    = to_bcd(year % 100);
        s.month   = to_bcd(month);
        s.day     = to_bcd(day);
        s.hour    = to_bcd(hour);
        s.minute  = to_bcd(minute);
        s.second  = to_bcd(second);
      end
      if (!s.hour24) s.hour[7] = pm;
    end
    return s;
  endfunction

  // Offers one snapshot, with random idle cycles in front, and waits for
  // its transfer. The valid stays high when no idle cycle follows.
  task automatic send_snapshot(snapshot_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.century, s.year, s.month, s.day, s.hour, s.minute, s.second};
    s_axis_tuser  <= {s.hour24, s.binary};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_snapshot(s);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_snapshot(random_snapshot());
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_epochs.size() != 0) @(posedge clk);
  endtask

  task automatic send_directed();
    // The epoch itself and the last second of the supported range.
    send_snapshot(make_snapshot(1, 1, 19, 70, 1, 1, 0, 0, 0));
    send_snapshot(make_snapshot(0, 1, 8'h20, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
    // Years just outside the range and months outside one to twelve.
    send_snapshot(make_snapshot(1, 1, 19, 69, 12, 31, 23, 59, 59));
    send_snapshot(make_snapshot(0, 1, 8'h21, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
    send_snapshot(make_snapshot(0, 1, 8'h20, 8'h24, 8'h00, 8'h10, 8'h10, 8'h10, 8'h10));
    send_snapshot(make_snapshot(0, 1, 8'h20, 8'h24, 8'h13, 8'h10, 8'h10, 8'h10, 8'h10));
    send_snapshot(make_snapshot(1, 1, 20, 24, 13, 10, 10, 10, 10));
    // Twelve-hour conversions: midnight, noon, afternoon, morning.
    send_snapshot(make_snapshot(0, 0, 8'h20, 8'h24, 8'h06, 8'h15, 8'h12, 8'h30, 8'h45));
    send_snapshot(make_snapshot(0, 0, 8'h20, 8'h24, 8'h06, 8'h15, 8'h92, 8'h30, 8'h45));
    send_snapshot(make_snapshot(0, 0, 8'h20, 8'h24, 8'h06, 8'h15, 8'h81, 8'h30, 8'h45));
    send_snapshot(make_snapshot(0, 0, 8'h20, 8'h24, 8'h06, 8'h15, 8'h11, 8'h30, 8'h45));
    send_snapshot(make_snapshot(1, 0, 20, 24, 6, 15, 8'h8B, 30, 45));
    send_snapshot(make_snapshot(1, 0, 20, 24, 6, 15, 12, 30, 45));
    // In 24-hour mode the top hour bit is kept as part of the value.
    send_snapshot(make_snapshot(1, 1, 20, 24, 6, 15, 8'h80, 0, 0));
    send_snapshot(make_snapshot(0, 1, 8'h20, 8'h24, 8'h06, 8'h15, 8'hA3, 8'h00, 8'h00));
    // BCD nibbles above nine are decoded without complaint.
    send_snapshot(make_snapshot(0, 1, 8'h20, 8'h10, 8'h07, 8'h04, 8'h05, 8'hFA, 8'hFF));
    // Day zero falls one day before the first of the month.
    send_snapshot(make_snapshot(1, 1, 19, 70, 1, 0, 0, 0, 0));
    // Leap years around February.
    send_snapshot(make_snapshot(0, 1, 8'h20, 8'h00, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00));
    send_snapshot(make_snapshot(0, 1, 8'h20, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
    send_snapshot(make_snapshot(1, 1, 20, 24, 3, 1, 0, 0, 0));
    send_snapshot(make_snapshot(1, 1, 20, 23, 3, 1, 0, 0, 0));
    // All ones in both encodings and all zeros in BCD.
    send_snapshot(make_snapshot(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_snapshot(make_snapshot(1, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_snapshot(make_snapshot(0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // Result side: random back-pressure, and every transfer is checked.
  initial begin : result_sink
    forever begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles now and then, receiver mostly stalls.
    send_directed();
    send_random(RANDOM_PER_PHASE);
    hold_until_drained();

    // The other way round.
    send_idle_pct = 81;
    recv_idle_pct = 29;
    send_random(RANDOM_PER_PHASE);
    hold_until_drained();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);
    hold_until_drained();

    // A few more cycles so that a stray extra result would still be seen.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited_epochs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
